// ----- hw/rtl/video_beam_position_tracker_core_defines.svh -----
// Assertion macros for the video beam position tracker.
// Included by the checker; no other dependencies.
`ifndef VIDEO_BEAM_POSITION_TRACKER_CORE_DEFINES_SVH
`define VIDEO_BEAM_POSITION_TRACKER_CORE_DEFINES_SVH

// Property checked only while out of reset.
`define VBPT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("vbpt assertion failed");

// Property checked during reset as well.
`define VBPT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("vbpt assertion failed");

`endif

// ----- hw/rtl/vbpt_pkg.sv -----
// Shared types and constants for the video beam position tracker.
// No dependencies.
`default_nettype none

package vbpt_pkg;

    typedef enum logic [1:0] {
        VM_VSYNC  = 2'd0,
        VM_VBLANK = 2'd1,
        VM_DRAW   = 2'd2,
        VM_OVER   = 2'd3
    } vmode_t;

    typedef enum logic [1:0] {
        HM_SYNC = 2'd0,
        HM_DRAW = 2'd1,
        HM_IDLE = 2'd2
    } hmode_t;

    typedef enum logic [1:0] {
        ACT_CYCLES = 2'd0,
        ACT_HSYNC  = 2'd1,
        ACT_VBLANK = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        CFG_LINE_WIDTH     = 2'd0,
        CFG_HSYNC_WIDTH    = 2'd1,
        CFG_VISIBLE_LINES  = 2'd2,
        CFG_OVERSCAN_LINES = 2'd3
    } cfg_idx_t;

    localparam int CfgDataW = 9;

    localparam logic [7:0] LINE_WIDTH_RST     = 8'd160;
    localparam logic [6:0] HSYNC_WIDTH_RST    = 7'd68;
    localparam logic [8:0] VISIBLE_LINES_RST  = 9'd192;
    localparam logic [7:0] OVERSCAN_LINES_RST = 8'd30;

    // -HSYNC_WIDTH_RST in 10-bit two's complement
    localparam logic signed [9:0] BEAM_X_RST = 10'sd0 - $signed({3'b000, HSYNC_WIDTH_RST});

    localparam int BLANK_BIT = 1;

    typedef struct packed {
        logic [7:0] line_width;
        logic [6:0] hsync_width;
        logic [8:0] visible_lines;
        logic [7:0] overscan_lines;
    } beam_cfg_t;

    typedef struct packed {
        logic signed [9:0] x;
        logic [9:0]        y;
        logic signed [9:0] wrap_x;
        vmode_t            vmode;
        hmode_t            hmode;
    } beam_state_t;

    typedef struct packed {
        logic              line_done;
        logic [9:0]        line_number;
        logic signed [9:0] clock_adjust;
        logic              frame_ready;
    } beam_event_t;

endpackage

`default_nettype wire

// ----- hw/rtl/video_beam_position_tracker_core.sv -----
// Top level of the video beam position tracker: stream ports, config
// registers, input and result registers. Depends on vbpt_pkg and vbpt_step.
//
//  channel  | signals                          | contents
//  ---------+----------------------------------+-----------------------------------
//  input    | s_tvalid s_tready s_tdata s_tuser| one request: action, cycles, blank
//  result   | m_tvalid m_tready m_tdata        | one result per request
//  config   | cfg_wr_en cfg_addr cfg_wdata     | register write, no handshake
//
// One request per clock sustained while m_tready holds; an accepted request
// passes the input register, then the step logic into the result register,
// which drives m_tvalid; a stall on m_tready can hold it in either register.
// aresetn is synchronous: both stages empty, beam state and config at defaults.
// A stalled result holds in the result register while the input register
// still takes one more request; s_tready drops only when both are full.
`default_nettype none

module video_beam_position_tracker_core
    import vbpt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // cpu_cycles[5:0], blank_value[13:6], zero[15:14]
    input  logic [1:0]          s_tuser,   // action[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    // line_done[0], line_number[10:1], clock_adjust[20:11], frame_ready[21],
    // beam_x[31:22], beam_y[41:32], line_start_x[51:42], vertical_mode[53:52],
    // horizontal_mode[55:54]
    output logic [55:0]         m_tdata,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_addr,
    input  logic [CfgDataW-1:0] cfg_wdata
);

    beam_cfg_t   cfg_reg;
    beam_state_t state_reg, state_next;
    beam_event_t ev_next;

    logic        in_valid_reg;
    action_t     in_action_reg;
    logic [5:0]  in_cycles_reg;
    logic [7:0]  in_blank_reg;

    logic        out_valid_reg;
    beam_state_t out_state_reg;
    beam_event_t out_ev_reg;

    logic out_free;
    logic step_fire;

    assign out_free  = !out_valid_reg || m_tready;
    assign step_fire = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_width     <= LINE_WIDTH_RST;
            cfg_reg.hsync_width    <= HSYNC_WIDTH_RST;
            cfg_reg.visible_lines  <= VISIBLE_LINES_RST;
            cfg_reg.overscan_lines <= OVERSCAN_LINES_RST;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_LINE_WIDTH:     cfg_reg.line_width     <= cfg_wdata[7:0];
                CFG_HSYNC_WIDTH:    cfg_reg.hsync_width    <= cfg_wdata[6:0];
                CFG_VISIBLE_LINES:  cfg_reg.visible_lines  <= cfg_wdata[8:0];
                CFG_OVERSCAN_LINES: cfg_reg.overscan_lines <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    vbpt_step u_step (
        .cfg         (cfg_reg),
        .st          (state_reg),
        .action      (in_action_reg),
        .cpu_cycles  (in_cycles_reg),
        .blank_value (in_blank_reg),
        .nxt         (state_next),
        .ev          (ev_next)
    );

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_action_reg <= action_t'(s_tuser);
            in_cycles_reg <= s_tdata[5:0];
            in_blank_reg  <= s_tdata[13:6];
        end
    end

    // beam state advances once per request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.x      <= BEAM_X_RST;
            state_reg.y      <= '0;
            state_reg.wrap_x <= '0;
            state_reg.vmode  <= VM_VSYNC;
            state_reg.hmode  <= HM_IDLE;
        end else if (step_fire) begin
            state_reg <= state_next;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_fire) begin
            out_state_reg <= state_next;
            out_ev_reg    <= ev_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_state_reg.hmode, out_state_reg.vmode, out_state_reg.wrap_x,
                       out_state_reg.y, out_state_reg.x, out_ev_reg.frame_ready,
                       out_ev_reg.clock_adjust, out_ev_reg.line_number,
                       out_ev_reg.line_done};

endmodule

`default_nettype wire

// ----- hw/rtl/vbpt_step.sv -----
// Next-state and event logic for one beam tracker request.
// Depends on vbpt_pkg.
`default_nettype none

module vbpt_step
    import vbpt_pkg::*;
(
    input  beam_cfg_t   cfg,
    input  beam_state_t st,
    input  action_t     action,
    input  logic [5:0]  cpu_cycles,
    input  logic [7:0]  blank_value,
    output beam_state_t nxt,
    output beam_event_t ev
);

    logic [7:0]        pix_step;
    logic signed [9:0] adv_x;
    logic              adv_ge_w;
    logic [8:0]        span;
    logic signed [9:0] adv_wrapped;
    logic [9:0]        y_inc;
    logic [9:0]        frame_lines;
    logic signed [9:0] neg_hs;
    logic              x_past_sync;
    logic signed [10:0] diff;
    logic [9:0]        mag;
    logic [19:0]       prod;
    logic [8:0]        quot;
    logic signed [9:0] adjust;

    // three pixels per cpu cycle
    assign pix_step    = {2'b00, cpu_cycles} + {1'b0, cpu_cycles, 1'b0};
    assign adv_x       = st.x + $signed({2'b00, pix_step});
    assign adv_ge_w    = $signed({adv_x[9], adv_x}) >= $signed({3'b000, cfg.line_width});
    assign span        = {1'b0, cfg.line_width} + {2'b00, cfg.hsync_width};
    assign adv_wrapped = adv_x - $signed({1'b0, span});
    assign y_inc       = st.y + 10'd1;
    assign frame_lines = {1'b0, cfg.visible_lines} + {2'b00, cfg.overscan_lines};
    assign neg_hs      = 10'sd0 - $signed({3'b000, cfg.hsync_width});
    assign x_past_sync = $signed({st.x[9], st.x}) > $signed({neg_hs[9], neg_hs});

    // (x - width) / 3 toward zero: magnitude times 683/2048, exact below 2048
    assign diff   = $signed({st.x[9], st.x}) - $signed({3'b000, cfg.line_width});
    assign mag    = diff[10] ? 10'(-diff) : diff[9:0];
    assign prod   = mag * 10'd683;
    assign quot   = prod[19:11];
    assign adjust = diff[10] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

    always_comb begin
        nxt = st;
        ev  = '0;
        case (action)
            ACT_CYCLES: begin
                if (st.vmode != VM_OVER && st.hmode != HM_IDLE) begin
                    nxt.x = adv_x;
                    if (st.hmode == HM_SYNC) begin
                        if (!adv_x[9]) begin
                            nxt.hmode = HM_DRAW;
                        end
                    end else if (st.vmode != VM_DRAW) begin
                        if (adv_ge_w) begin
                            nxt.x      = adv_wrapped;
                            nxt.wrap_x = adv_wrapped;
                            nxt.hmode  = HM_SYNC;
                        end
                    end else begin
                        if (adv_ge_w) begin
                            nxt.wrap_x        = adv_x;
                            nxt.x             = adv_wrapped;
                            ev.line_done      = 1'b1;
                            ev.line_number    = st.y;
                            nxt.y             = y_inc;
                            nxt.hmode         = HM_SYNC;
                        end
                        if (nxt.y >= frame_lines) begin
                            nxt.vmode = VM_OVER;
                            nxt.y     = '0;
                        end
                    end
                end
            end
            ACT_HSYNC: begin
                if (st.vmode == VM_DRAW && x_past_sync) begin
                    ev.line_done    = 1'b1;
                    ev.line_number  = st.y;
                    ev.clock_adjust = adjust;
                    nxt.y           = y_inc;
                end
                nxt.hmode  = HM_SYNC;
                nxt.x      = neg_hs;
                nxt.wrap_x = '0;
            end
            ACT_VBLANK: begin
                if (blank_value[BLANK_BIT]) begin
                    nxt.vmode      = VM_VBLANK;
                    ev.frame_ready = 1'b1;
                end else begin
                    nxt.vmode = VM_DRAW;
                    nxt.hmode = HM_SYNC;
                    nxt.x     = neg_hs;
                    nxt.y     = '0;
                end
            end
            default: begin
                // unused code: state holds, no event
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/vbpt_checker.sv -----
// Port-level checks for the video beam position tracker, bound to the top.
// Depends on vbpt_pkg and video_beam_position_tracker_core_defines.svh.
`default_nettype none
`include "video_beam_position_tracker_core_defines.svh"

module vbpt_checker
    import vbpt_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    logic       line_done;
    logic [9:0] clock_adjust;
    logic       frame_ready;
    logic [1:0] vmode;
    logic [1:0] hmode;
    logic       frame_clean;

    assign line_done    = m_tdata[0];
    assign clock_adjust = m_tdata[20:11];
    assign frame_ready  = m_tdata[21];
    assign vmode        = m_tdata[53:52];
    assign hmode        = m_tdata[55:54];
    assign frame_clean  = (vmode == VM_VBLANK) && !line_done && (clock_adjust == 10'd0);

    // stalled result holds
    `VBPT_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // nothing comes out right after reset
    `VBPT_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

    // every emitted line leaves the beam in horizontal sync
    `VBPT_ASSERT(a_line_sync, aclk, aresetn, m_tvalid && line_done |-> hmode == HM_SYNC)

    // frame ready comes only from a vblank write, with no line event
    `VBPT_ASSERT(a_frame, aclk, aresetn, m_tvalid && frame_ready |-> frame_clean)

    // clock correction only with an hsync line
    `VBPT_ASSERT(a_adjust, aclk, aresetn, m_tvalid && clock_adjust != 10'd0 |-> line_done)

endmodule

bind video_beam_position_tracker_core vbpt_checker u_vbpt_checker (.*);

`default_nettype wire
